### hw/rtl/isovalue_span_histogram_defines.svh
// assertion macros for the isovalue span histogram
`ifndef ISOVALUE_SPAN_HISTOGRAM_DEFINES_SVH
`define ISOVALUE_SPAN_HISTOGRAM_DEFINES_SVH
// implication checked on every clock edge outside reset
`define ISH_ASSERT_IMPLY(label, clk_s, rst_s, cond, prop, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (cond) |-> (prop)) \
        else $error(msg);
// property checked in the cycle after the condition
`define ISH_ASSERT_NEXT(label, clk_s, rst_s, cond, prop, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (cond) |=> (prop)) \
        else $error(msg);
`endif

### hw/rtl/ish_pkg.sv
// shared types and constants of the isovalue span histogram
package ish_pkg;
    localparam int VALUE_W = 8;
    localparam int COUNT_W = 19;
    localparam int BINS    = 256;
    localparam int BIN_W   = 8;
    localparam int SIZE_W  = 7;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;
    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_BIN     = 1'b1;

    localparam logic [1:0] REG_SIZE_X = 2'd0;
    localparam logic [1:0] REG_SIZE_Y = 2'd1;
    localparam logic [1:0] REG_SIZE_Z = 2'd2;

    // datapath commands
    typedef struct packed {
        logic store_voxel;   // write input voxel, advance load counter
        logic clear_hist;    // start a clear sweep pass step
        logic cell_step;     // visit one cell corner read
        logic scan_step;     // prefix scan step
        logic read_bin;      // issue bin read
        logic reset_scan;    // reset scan/cell counters
    } ish_cmd_t;

    typedef struct packed {
        logic volume_full;   // load counter is at the last voxel
        logic first_voxel;   // load counter is zero
        logic cells_done;
        logic scan_done;
        logic clear_done;
    } ish_stat_t;
endpackage

### hw/rtl/ish_ram.sv
// generic single-port-write ram with registered read
module ish_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### hw/rtl/ish_datapath.sv
// voxel store, cell walk, difference histogram and peak scan
module ish_datapath #(
    parameter int MAX_X = 64,
    parameter int MAX_Y = 64,
    parameter int MAX_Z = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ish_pkg::ish_cmd_t            cmd,
    output ish_pkg::ish_stat_t           stat,
    input  logic                         restart,
    input  logic [ish_pkg::SIZE_W-1:0]   size_x,
    input  logic [ish_pkg::SIZE_W-1:0]   size_y,
    input  logic [ish_pkg::SIZE_W-1:0]   size_z,
    input  logic [ish_pkg::VALUE_W-1:0]  voxel_value,
    input  logic [ish_pkg::BIN_W-1:0]    bin_index,
    output logic [ish_pkg::COUNT_W-1:0]  bin_count,
    output logic [ish_pkg::COUNT_W-1:0]  peak_count
);
    import ish_pkg::*;

    localparam int XW = $clog2(MAX_X);
    localparam int YW = $clog2(MAX_Y);
    localparam int ZW = $clog2(MAX_Z);
    localparam int AW = XW + YW + ZW;
    localparam int DEPTH = 1 << AW;
    localparam int XC = $clog2(MAX_X + 1);
    localparam int YC = $clog2(MAX_Y + 1);
    localparam int ZC = $clog2(MAX_Z + 1);

    // effective sizes
    logic [XC-1:0] sx;
    logic [YC-1:0] sy;
    logic [ZC-1:0] sz;

    function automatic logic [10:0] clampv(input logic [SIZE_W-1:0] raw, input int top);
        logic [10:0] r;
        r = {4'd0, raw};
        if (r == 11'd0) r = 11'd1;
        if (r > 11'(top)) r = 11'(top);
        return r;
    endfunction

    assign sx = XC'(clampv(size_x, MAX_X));
    assign sy = YC'(clampv(size_y, MAX_Y));
    assign sz = ZC'(clampv(size_z, MAX_Z));

    // load position, and cell position during the walk
    logic [XW-1:0] lx_reg, cx_reg;
    logic [YW-1:0] ly_reg, cy_reg;
    logic [ZW-1:0] lz_reg, cz_reg;
    logic [2:0]    corner_reg;
    logic          walk_end_reg;
    logic          pend_reg;    // a corner read is in flight
    logic          pend_last_reg;
    logic          pend_first_reg;
    logic [VALUE_W-1:0] lo_reg, hi_reg;

    // steps stop once the last cell or the last bin has been issued
    logic cell_go;
    logic scan_go;

    logic last_x, last_y, last_z;
    assign last_x = ({1'b0, lx_reg} == XC'(sx - 1'b1));
    assign last_y = ({1'b0, ly_reg} == YC'(sy - 1'b1));
    assign last_z = ({1'b0, lz_reg} == ZC'(sz - 1'b1));

    // voxel store, addressed as z:y:x fields
    logic          st_we;
    logic [AW-1:0] st_waddr, st_raddr;
    logic [VALUE_W-1:0] st_rdata;
    assign st_we    = cmd.store_voxel;
    assign st_waddr = {lz_reg, ly_reg, lx_reg};

    // corner neighbor, clipped at far faces
    logic cdx, cdy, cdz;
    logic [XW-1:0] nx;
    logic [YW-1:0] ny;
    logic [ZW-1:0] nz;
    always_comb
    begin
        cdx = corner_reg[0] && ({1'b0, cx_reg} != XC'(sx - 1'b1));
        cdy = corner_reg[1] && ({1'b0, cy_reg} != YC'(sy - 1'b1));
        cdz = corner_reg[2] && ({1'b0, cz_reg} != ZC'(sz - 1'b1));
        nx = cx_reg + XW'(cdx);
        ny = cy_reg + YW'(cdy);
        nz = cz_reg + ZW'(cdz);
    end
    assign st_raddr = {nz, ny, nx};

    ish_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_store (
        .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(voxel_value),
        .raddr(st_raddr), .rdata(st_rdata)
    );

    // difference array, kept as two 256-entry rams of counts
    // add ram: entry lo counts +1, sub ram: entry hi counts -1 at hi+1
    logic [BIN_W-1:0] scan_reg;
    logic [8:0]       clr_reg;
    logic             scan_end_reg;
    logic             upd_reg;
    logic [BIN_W-1:0] upd_lo_reg, upd_hi_reg;
    logic [BIN_W-1:0] bin_sel_reg;   // bin of the read item being answered
    logic [COUNT_W-1:0] add_rd, sub_rd, hist_rd;
    logic [BIN_W-1:0] add_ra, sub_ra, hist_ra;
    logic add_we, sub_we, hist_we;
    logic [BIN_W-1:0] add_wa, sub_wa, hist_wa;
    logic [COUNT_W-1:0] add_wd, sub_wd, hist_wd;

    // read-modify-write of the difference rams reads both entries, then writes back:
    // the cell walk issues one update per cell, after its 8 corner reads, so no hazard
    logic [1:0] rmw_reg;

    ish_ram #(.WIDTH(COUNT_W), .DEPTH(BINS)) u_add (
        .clk(clk), .we(add_we), .waddr(add_wa), .wdata(add_wd),
        .raddr(add_ra), .rdata(add_rd)
    );
    ish_ram #(.WIDTH(COUNT_W), .DEPTH(BINS)) u_sub (
        .clk(clk), .we(sub_we), .waddr(sub_wa), .wdata(sub_wd),
        .raddr(sub_ra), .rdata(sub_rd)
    );
    ish_ram #(.WIDTH(COUNT_W), .DEPTH(BINS)) u_hist (
        .clk(clk), .we(hist_we), .waddr(hist_wa), .wdata(hist_wd),
        .raddr(hist_ra), .rdata(hist_rd)
    );

    logic clearing;
    assign clearing = cmd.clear_hist;

    assign cell_go = cmd.cell_step && !walk_end_reg;
    assign scan_go = cmd.scan_step && !scan_end_reg;

    // running sum during scan; sub ram entry b holds decrements at b
    logic [COUNT_W-1:0] run_reg;
    logic [COUNT_W-1:0] peak_reg;
    logic [COUNT_W-1:0] run_now;
    logic               scan_pend_reg;
    logic [BIN_W-1:0]   scan_wa_reg;
    assign run_now = run_reg + add_rd - sub_rd;

    always_comb
    begin
        add_ra = upd_lo_reg;
        sub_ra = upd_hi_reg;
        hist_ra = bin_sel_reg;
        add_we = 1'b0; sub_we = 1'b0; hist_we = 1'b0;
        add_wa = clr_reg[BIN_W-1:0]; sub_wa = clr_reg[BIN_W-1:0];
        hist_wa = clr_reg[BIN_W-1:0];
        add_wd = '0; sub_wd = '0; hist_wd = '0;
        if (clearing)
        begin
            add_we = 1'b1; sub_we = 1'b1; hist_we = 1'b1;
        end
        else if (rmw_reg == 2'd1)
        begin
            add_we = 1'b1; add_wa = upd_lo_reg; add_wd = add_rd + 1'b1;
            // hi = 255 drops off the end of the histogram
            sub_we = (upd_hi_reg != BIN_W'(BINS - 1));
            sub_wa = upd_hi_reg + 1'b1; sub_wd = sub_rd + 1'b1;
        end
        if (rmw_reg == 2'd0 && upd_reg)
        begin
            sub_ra = upd_hi_reg + 1'b1;
        end
        if (cmd.scan_step || cmd.reset_scan)
        begin
            add_ra = scan_reg;
            sub_ra = scan_reg;
        end
        if (scan_pend_reg)
        begin
            hist_we = 1'b1; hist_wa = scan_wa_reg; hist_wd = run_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lx_reg <= '0; ly_reg <= '0; lz_reg <= '0;
            cx_reg <= '0; cy_reg <= '0; cz_reg <= '0;
            corner_reg <= '0; walk_end_reg <= 1'b0;
            pend_reg <= 1'b0; pend_last_reg <= 1'b0; pend_first_reg <= 1'b0;
            upd_reg <= 1'b0; rmw_reg <= '0;
            clr_reg <= '0; scan_reg <= '0; scan_end_reg <= 1'b0;
            scan_pend_reg <= 1'b0; scan_wa_reg <= '0;
            run_reg <= '0; peak_reg <= '0;
            lo_reg <= '0; hi_reg <= '0;
            upd_lo_reg <= '0; upd_hi_reg <= '0;
            bin_sel_reg <= '0;
        end
        else
        begin
            if (restart)
            begin
                lx_reg <= '0; ly_reg <= '0; lz_reg <= '0;
            end
            else if (cmd.store_voxel)
            begin
                if (last_x)
                begin
                    lx_reg <= '0;
                    if (last_y)
                    begin
                        ly_reg <= '0;
                        lz_reg <= last_z ? '0 : lz_reg + 1'b1;
                    end
                    else
                    begin
                        ly_reg <= ly_reg + 1'b1;
                    end
                end
                else
                begin
                    lx_reg <= lx_reg + 1'b1;
                end
            end

            if (cmd.read_bin)
            begin
                bin_sel_reg <= bin_index;
            end

            // clear sweep
            if (cmd.clear_hist)
            begin
                clr_reg <= clr_reg + 1'b1;
                peak_reg <= '0;
            end
            else
            begin
                clr_reg <= '0;
            end

            // cell walk: one corner read per step
            pend_reg <= cell_go;
            pend_first_reg <= cell_go && (corner_reg == 3'd0);
            pend_last_reg <= cell_go && (corner_reg == 3'd7);
            if (cmd.reset_scan)
            begin
                cx_reg <= '0; cy_reg <= '0; cz_reg <= '0; corner_reg <= '0;
                walk_end_reg <= 1'b0;
            end
            else if (cell_go)
            begin
                corner_reg <= corner_reg + 1'b1;
                if (corner_reg == 3'd7)
                begin
                    if ({1'b0, cx_reg} == XC'(sx - 1'b1))
                    begin
                        cx_reg <= '0;
                        if ({1'b0, cy_reg} == YC'(sy - 1'b1))
                        begin
                            cy_reg <= '0;
                            if ({1'b0, cz_reg} == ZC'(sz - 1'b1))
                            begin
                                walk_end_reg <= 1'b1;
                            end
                            cz_reg <= cz_reg + 1'b1;
                        end
                        else
                        begin
                            cy_reg <= cy_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        cx_reg <= cx_reg + 1'b1;
                    end
                end
            end

            upd_reg <= 1'b0;
            if (pend_reg)
            begin
                if (pend_first_reg)
                begin
                    lo_reg <= st_rdata; hi_reg <= st_rdata;
                end
                else
                begin
                    if (st_rdata < lo_reg) lo_reg <= st_rdata;
                    if (st_rdata > hi_reg) hi_reg <= st_rdata;
                end
                if (pend_last_reg)
                begin
                    upd_reg <= 1'b1;
                    upd_lo_reg <= pend_first_reg ? st_rdata :
                        ((st_rdata < lo_reg) ? st_rdata : lo_reg);
                    upd_hi_reg <= pend_first_reg ? st_rdata :
                        ((st_rdata > hi_reg) ? st_rdata : hi_reg);
                end
            end

            // update pipeline: issue reads, then write back
            if (upd_reg)
            begin
                rmw_reg <= 2'd1;
            end
            else
            begin
                rmw_reg <= 2'd0;
            end

            // prefix scan: each entry read is registered, then summed
            scan_pend_reg <= scan_go;
            scan_wa_reg <= scan_reg;
            if (cmd.reset_scan)
            begin
                scan_reg <= '0; scan_end_reg <= 1'b0; run_reg <= '0;
            end
            else if (scan_go)
            begin
                scan_reg <= scan_reg + 1'b1;
                if (scan_reg == BIN_W'(BINS - 1)) scan_end_reg <= 1'b1;
            end
            if (scan_pend_reg)
            begin
                run_reg <= run_now;
                if (scan_wa_reg == BIN_W'(1))
                begin
                    peak_reg <= run_now;
                end
                else if (scan_wa_reg != '0 && run_now > peak_reg)
                begin
                    peak_reg <= run_now;
                end
            end
        end
    end

    assign bin_count  = hist_rd;
    assign peak_count = peak_reg;

    always_comb
    begin
        stat.volume_full = last_x && last_y && last_z;
        stat.first_voxel = (lx_reg == '0) && (ly_reg == '0) && (lz_reg == '0);
        stat.cells_done  = walk_end_reg && !pend_reg && !upd_reg && (rmw_reg == 2'd0);
        stat.scan_done   = scan_end_reg && !scan_pend_reg;
        stat.clear_done  = clr_reg == 9'(BINS - 1);
    end
endmodule

### hw/rtl/ish_ctrl.sv
// sequencer of the isovalue span histogram
module ish_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_tvalid,
    output logic                 in_tready,
    input  logic                 opcode,
    output logic                 out_tvalid,
    input  logic                 out_tready,
    output logic                 out_kind,
    output ish_pkg::ish_cmd_t    cmd,
    input  ish_pkg::ish_stat_t   stat
);
    import ish_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CLEAR, ST_WALK, ST_SCAN0, ST_SCAN, ST_READ, ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   kind_reg, kind_next;
    logic   valid_reg, valid_next;
    logic   clear_then_store_reg, cts_next;
    logic   accept;

    assign in_tready  = (state_reg == ST_IDLE) && !valid_reg;
    assign accept     = in_tvalid && in_tready;
    assign out_tvalid = valid_reg;
    assign out_kind   = kind_reg;

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        valid_next = valid_reg && !out_tready;
        cts_next   = clear_then_store_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == OP_READ)
                    begin
                        cmd.read_bin = 1'b1;
                        state_next = ST_READ;
                    end
                    else
                    begin
                        cmd.store_voxel = 1'b1;
                        if (stat.first_voxel)
                        begin
                            cts_next = stat.volume_full;
                            state_next = ST_CLEAR;
                        end
                        else if (stat.volume_full)
                        begin
                            cmd.reset_scan = 1'b1;
                            state_next = ST_WALK;
                        end
                    end
                end
            end
            ST_CLEAR:
            begin
                cmd.clear_hist = 1'b1;
                if (stat.clear_done)
                begin
                    if (clear_then_store_reg)
                    begin
                        cmd.reset_scan = 1'b1;
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_WALK:
            begin
                cmd.cell_step = !stat.cells_done;
                if (stat.cells_done)
                begin
                    state_next = ST_SCAN0;
                end
            end
            ST_SCAN0:
            begin
                cmd.reset_scan = 1'b1;
                cmd.scan_step  = 1'b0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan_step = !stat.scan_done;
                if (stat.scan_done)
                begin
                    kind_next  = KIND_SUMMARY;
                    valid_next = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_READ:
            begin
                kind_next  = KIND_BIN;
                valid_next = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!valid_reg || out_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // reset starts with a clear sweep so the histogram reads zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            kind_reg  <= KIND_SUMMARY;
            valid_reg <= 1'b0;
            clear_then_store_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            valid_reg <= valid_next;
            clear_then_store_reg <= cts_next;
        end
    end
endmodule

### hw/rtl/isovalue_span_histogram.sv
// top level of the isovalue span histogram
// usage:
//   s_axis carries one item per handshake: opcode, voxel value, bin index.
//   a load item (opcode 0) stores the next voxel in raster order, x fastest.
//   the first load of a volume clears all 256 bins of the histogram.
//   the last load of a volume walks all cells, 8 store reads per cell,
//   then a 256-step prefix scan builds the bins and the peak over bins
//   1 to 255; one summary item (tuser 0) then leaves on m_axis.
//   a read item (opcode 1) answers bin count and peak.
//   an ordinary load returns straight to idle; the summary follows the
//   cell walk and the scan, paced by the single store read port.
//   one item is worked at a time; input waits while a result is held.
//   the result item is held steady while the receiver stalls, until taken.
//   reset clears the counters and runs a clear sweep of all 256 histogram
//   entries, with input held off; reads then return zero until a volume
//   completes; size writes on the cfg port restart the volume being loaded.
module isovalue_span_histogram #(
    parameter int MAX_X = 64,
    parameter int MAX_Y = 64,
    parameter int MAX_Z = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[0], voxel_value[8:1], bin_index[16:9], zero fill
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // bin_count[18:0], peak_count[37:19], zero fill
    output logic [39:0] m_axis_tdata,
    // result_kind[0]
    output logic        m_axis_tuser,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data
);
    import ish_pkg::*;

    logic [SIZE_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    ish_cmd_t  cmd;
    ish_stat_t stat;
    logic [COUNT_W-1:0] bin_count, peak_count;
    logic [COUNT_W-1:0] bin_q_reg, peak_q_reg;
    logic kind;
    logic restart;

    // any write in range restarts the volume
    assign restart = cfg_we && (cfg_index == REG_SIZE_X || cfg_index == REG_SIZE_Y
                                || cfg_index == REG_SIZE_Z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= 7'd64; size_y_reg <= 7'd64; size_z_reg <= 7'd64;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SIZE_X: size_x_reg <= cfg_data;
                REG_SIZE_Y: size_y_reg <= cfg_data;
                REG_SIZE_Z: size_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    ish_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_tvalid(s_axis_tvalid), .in_tready(s_axis_tready),
        .opcode(s_axis_tdata[0]),
        .out_tvalid(m_axis_tvalid), .out_tready(m_axis_tready),
        .out_kind(kind), .cmd(cmd), .stat(stat)
    );

    ish_datapath #(.MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .restart(restart),
        .size_x(size_x_reg), .size_y(size_y_reg), .size_z(size_z_reg),
        .voxel_value(s_axis_tdata[8:1]), .bin_index(s_axis_tdata[16:9]),
        .bin_count(bin_count), .peak_count(peak_count)
    );

    // capture answer into the output register the cycle it becomes valid
    logic capture;
    logic valid_d_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_d_reg <= 1'b0;
        end
        else
        begin
            valid_d_reg <= m_axis_tvalid;
        end
    end
    assign capture = m_axis_tvalid && !valid_d_reg;

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            bin_q_reg  <= (kind == KIND_BIN) ? bin_count : '0;
            peak_q_reg <= peak_count;
        end
    end

    assign m_axis_tuser = kind;
    assign m_axis_tdata = capture
        ? {2'b00, peak_count, ((kind == KIND_BIN) ? bin_count : COUNT_W'(0))}
        : {2'b00, peak_q_reg, bin_q_reg};
endmodule

### hw/rtl/ish_checker.sv
// port-level checks of the isovalue span histogram
`include "isovalue_span_histogram_defines.svh"
module ish_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    `ISH_ASSERT_IMPLY(a_no_take_while_held, clk, rst_n, m_axis_tvalid, !s_axis_tready,
        "input taken while a result is held")
    `ISH_ASSERT_IMPLY(a_summary_zero_bin, clk, rst_n, m_axis_tvalid && !m_axis_tuser,
        m_axis_tdata[18:0] == 19'd0, "summary item carries a bin count")
    `ISH_ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
endmodule

bind isovalue_span_histogram ish_checker u_ish_checker (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
